[rtl/pushpull_pot_sample_qualifier_top_assert.svh]
// ----------------------------------------------------------------------------
// Push-pull pot sample qualifier: assertion macros
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PUSHPULL_POT_SAMPLE_QUALIFIER_TOP_ASSERT_SVH
`define PUSHPULL_POT_SAMPLE_QUALIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PPSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppsq assertion failed");
// next-cycle implication
`define PPSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppsq assertion failed");
`else
`define PPSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PPSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/ppsq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Push-pull pot sample qualifier package
// Item types, register indexes, outcome codes and fixed constants.
// ----------------------------------------------------------------------------
package ppsq_pkg;

    typedef struct packed {
        logic [2:0]         pot_index;
        logic [11:0]        sense_before;
        logic [11:0]        sense_after;
        logic signed [15:0] wiper_sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  pot_number;
        logic [13:0] position;
        logic        pulled;
        logic [1:0]  outcome;
    } t_out_item;

    // configuration register indexes
    localparam int          CAL_COUNT    = 6;
    localparam logic [2:0]  REG_JUMP_THR = 3'd6;
    localparam logic [2:0]  REG_CONF_TOL = 3'd7;
    localparam logic [39:0] CAL_RESET [CAL_COUNT] = '{
        40'd620625779713, 40'd564790078465, 40'd619550978049,
        40'd1071595897857, 40'd605591250945, 40'd566937580545
    };
    localparam logic [13:0] JUMP_THR_RESET = 14'd1500;
    localparam logic [13:0] CONF_TOL_RESET = 14'd600;

    // outcome codes
    localparam logic [1:0] OUT_DISCARD  = 2'd0;
    localparam logic [1:0] OUT_MISMATCH = 2'd1;
    localparam logic [1:0] OUT_PENDING  = 2'd2;
    localparam logic [1:0] OUT_COMMIT   = 2'd3;

    // sense bands as sample codes (v = s * 3.3 / 4095)
    localparam logic [11:0] NRM_PULL_MAX  = 12'd186;   // below 0.15 V
    localparam logic [11:0] NRM_PRESS_MIN = 12'd1490;  // above 1.2 V
    localparam logic [11:0] MIR_PULL_MAX  = 12'd3102;  // below 2.5 V
    localparam logic [11:0] MIR_PRESS_MIN = 12'd3847;  // above 3.1 V
    localparam logic [2:0]  REVERSED_POT  = 3'd3;

    // resistance: 330 * raw / (26400 - raw) ohms
    localparam logic signed [15:0] RAW_OPEN_MIN  = 16'sd26000;
    localparam logic signed [15:0] RAW_SHORT_MAX = 16'sd8;
    localparam logic [15:0]        RD_BASE       = 16'd26400;
    localparam logic [9:0]         OHM_GAIN      = 10'd330;
    localparam logic [23:0]        OPEN_OHMS     = 24'd1000000;

    localparam logic [13:0] FULL_SCALE = 14'd10000;

    // sequencer step counts
    localparam logic [3:0] MUL_STEPS   = 4'd10;
    localparam logic [3:0] SCALE_STEPS = 4'd4;   // x5 four times = x625
    localparam logic [3:0] DIV_STEPS   = 4'd14;

endpackage

[rtl/pushpull_pot_sample_qualifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Push-pull pot sample qualifier
// Classifies switch sense, debounces pull state, turns the wiper sample into
// a calibrated position and filters jumps, one pot scan at a time.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  in       | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out      | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A full scan runs from accept to result through a check step, a 10-step
// bit-serial multiplier, four x5 scaling steps, a 14-step restoring divider
// and the mirror and update steps. Discarded, mismatched, out-of-range and
// zero-span scans go from the check step to the update step, clamped
// positions from the compare step. The next item is taken the cycle after
// the result is registered; a stalled result holds only the update step.
// Reset is synchronous; it restores calibration and clears all pot state.
// ----------------------------------------------------------------------------
`include "pushpull_pot_sample_qualifier_top_assert.svh"

module pushpull_pot_sample_qualifier_top
    import ppsq_pkg::*;
#(
    parameter int POT_COUNT          = 6,
    parameter int PULL_CONFIRM_COUNT = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data
);

    localparam int IDX_W = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1;
    localparam int CNT_W = $clog2(PULL_CONFIRM_COUNT + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_MUL, S_NUM, S_CMP, S_SCALE, S_DINIT, S_DIV, S_MIR, S_UPD
    } t_state;

    typedef enum logic [1:0] {
        CLS_PRESSED, CLS_PULLED, CLS_FLIGHT
    } t_cls;

    function automatic t_cls classify(input logic [11:0] s, input logic mirror);
        t_cls c;
        c = CLS_FLIGHT;
        if (mirror) begin
            if (s >= MIR_PRESS_MIN)     c = CLS_PRESSED;
            else if (s <= MIR_PULL_MAX) c = CLS_PULLED;
        end else begin
            if (s <= NRM_PULL_MAX)       c = CLS_PULLED;
            else if (s >= NRM_PRESS_MIN) c = CLS_PRESSED;
        end
        return c;
    endfunction

    // configuration
    logic [39:0] r_cal [CAL_COUNT];
    logic [13:0] r_jump_thr;
    logic [13:0] r_conf_tol;

    // per-pot state
    logic [13:0]      r_committed [POT_COUNT];
    logic [13:0]      r_pending   [POT_COUNT];
    logic             r_pend_vld  [POT_COUNT];
    logic             r_pull      [POT_COUNT];
    logic [CNT_W-1:0] r_agree_cnt [POT_COUNT];

    // sequencer
    t_state     r_state;
    logic [3:0] r_cnt;
    t_in_item   r_in;
    logic [IDX_W-1:0] r_idx;
    logic       r_mirror;
    logic       r_pulled_now;
    logic       r_hold;
    logic       r_in_range;
    logic [1:0] r_outcome;
    logic       r_open;
    logic       r_span_neg;

    // serial multiplier
    logic [24:0] r_a_rd;
    logic [23:0] r_a_raw;
    logic [9:0]  r_m_lo;
    logic [9:0]  r_m_span;
    logic [9:0]  r_m_k;
    logic [24:0] r_acc_lo;
    logic [24:0] r_acc_den;
    logic [23:0] r_acc_rn;

    // scaling and divider
    logic signed [25:0] r_num;
    logic [34:0] r_x;
    logic [25:0] r_rem;
    logic [13:0] r_qsh;
    logic [13:0] r_p;

    // output stage
    logic      r_out_valid;
    t_out_item r_out;

    // combinational helpers
    logic        in_range;
    t_cls        cls_a;
    t_cls        cls_b;
    logic [39:0] cal_sel;
    logic [9:0]  cal_lo;
    logic [9:0]  cal_hi;
    logic        raw_open;
    logic        raw_short;
    logic [15:0] rd_full;
    logic [23:0] rn_eff;
    logic [25:0] rem_shift;
    logic        rem_ge;
    logic [38:0] dividend;
    logic [13:0] diff_c;
    logic [13:0] diff_p;
    logic [13:0] cur_c;
    logic [13:0] cur_p;
    logic [CNT_W-1:0] cnt_inc;
    logic        out_free;

    always_comb begin
        in_range  = int'(r_in.pot_index) < POT_COUNT;
        cls_a     = classify(r_in.sense_before, r_in.pot_index == REVERSED_POT);
        cls_b     = classify(r_in.sense_after,  r_in.pot_index == REVERSED_POT);
        cal_sel   = (int'(r_in.pot_index) < CAL_COUNT) ? r_cal[r_in.pot_index] : '0;
        cal_lo    = (cls_a == CLS_PULLED) ? cal_sel[29:20] : cal_sel[9:0];
        cal_hi    = (cls_a == CLS_PULLED) ? cal_sel[39:30] : cal_sel[19:10];
        raw_open  = r_in.wiper_sample >= RAW_OPEN_MIN;
        raw_short = r_in.wiper_sample <= RAW_SHORT_MAX;
        rd_full   = RD_BASE - r_in.wiper_sample;
        rn_eff    = r_open ? OPEN_OHMS : r_acc_rn;
        rem_shift = {r_rem[24:0], r_qsh[13]};
        rem_ge    = rem_shift >= {1'b0, r_acc_den};
        dividend  = {r_x, 4'b0000} + {15'b0, r_acc_den[24:1]};
        cur_c     = r_committed[r_idx];
        cur_p     = r_pending[r_idx];
        diff_c    = (r_p > cur_c) ? r_p - cur_c : cur_c - r_p;
        diff_p    = (r_p > cur_p) ? r_p - cur_p : cur_p - r_p;
        cnt_inc   = r_agree_cnt[r_idx] + 1'b1;
        out_free  = !r_out_valid || !i_out_stall;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAL_COUNT; i++) r_cal[i] <= CAL_RESET[i];
            r_jump_thr <= JUMP_THR_RESET;
            r_conf_tol <= CONF_TOL_RESET;
        end else if (i_cfg_we) begin
            if (int'(i_cfg_idx) < CAL_COUNT) begin
                r_cal[i_cfg_idx] <= i_cfg_data;
            end else if (i_cfg_idx == REG_JUMP_THR) begin
                r_jump_thr <= i_cfg_data[13:0];
            end else if (i_cfg_idx == REG_CONF_TOL) begin
                r_conf_tol <= i_cfg_data[13:0];
            end
        end
    end

    // pot state, sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < POT_COUNT; i++) begin
                r_committed[i] <= '0;
                r_pending[i]   <= '0;
                r_pend_vld[i]  <= 1'b0;
                r_pull[i]      <= 1'b0;
                r_agree_cnt[i] <= '0;
            end
        end else begin
            // the update step sets valid itself
            if (r_out_valid && !i_out_stall && r_state != S_UPD) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_CHK;
                    end
                end

                S_CHK: begin
                    r_idx        <= IDX_W'(r_in.pot_index);
                    r_in_range   <= in_range;
                    r_mirror     <= r_in.pot_index == REVERSED_POT;
                    r_pulled_now <= cls_a == CLS_PULLED;
                    r_open       <= raw_open;
                    r_span_neg   <= cal_hi < cal_lo;
                    r_p          <= '0;
                    r_a_rd       <= (raw_open || raw_short) ? 25'd1 : {10'b0, rd_full[14:0]};
                    r_a_raw      <= (raw_open || raw_short) ? '0
                                                            : {9'b0, r_in.wiper_sample[14:0]};
                    r_m_lo       <= cal_lo;
                    r_m_span     <= (cal_hi < cal_lo) ? cal_lo - cal_hi : cal_hi - cal_lo;
                    r_m_k        <= OHM_GAIN;
                    r_acc_lo     <= '0;
                    r_acc_den    <= '0;
                    r_acc_rn     <= '0;
                    r_cnt        <= MUL_STEPS - 1'b1;
                    if (!in_range || cls_a == CLS_FLIGHT) begin
                        r_hold    <= 1'b1;
                        r_outcome <= OUT_DISCARD;
                        r_state   <= S_UPD;
                    end else if (cls_a != cls_b) begin
                        r_hold    <= 1'b1;
                        r_outcome <= OUT_MISMATCH;
                        r_state   <= S_UPD;
                    end else if (cal_hi == cal_lo) begin
                        // zero span: position 0, no mirroring
                        r_hold  <= 1'b0;
                        r_state <= S_UPD;
                    end else begin
                        r_hold  <= 1'b0;
                        r_state <= S_MUL;
                    end
                end

                S_MUL: begin
                    // one multiplier bit per cycle for all three products
                    if (r_m_lo[0])   r_acc_lo  <= r_acc_lo + r_a_rd;
                    if (r_m_span[0]) r_acc_den <= r_acc_den + r_a_rd;
                    if (r_m_k[0])    r_acc_rn  <= r_acc_rn + r_a_raw;
                    r_m_lo   <= r_m_lo >> 1;
                    r_m_span <= r_m_span >> 1;
                    r_m_k    <= r_m_k >> 1;
                    r_a_rd   <= r_a_rd << 1;
                    r_a_raw  <= r_a_raw << 1;
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_NUM;
                end

                S_NUM: begin
                    // follow the sign of the span
                    r_num   <= r_span_neg ? $signed({1'b0, r_acc_lo} - {2'b0, rn_eff})
                                          : $signed({2'b0, rn_eff} - {1'b0, r_acc_lo});
                    r_state <= S_CMP;
                end

                S_CMP: begin
                    if (r_num[25] || r_num == '0) begin
                        r_p     <= r_mirror ? FULL_SCALE : '0;
                        r_state <= S_UPD;
                    end else if (r_num[24:0] >= r_acc_den) begin
                        r_p     <= r_mirror ? '0 : FULL_SCALE;
                        r_state <= S_UPD;
                    end else begin
                        r_x     <= {10'b0, r_num[24:0]};
                        r_cnt   <= SCALE_STEPS - 1'b1;
                        r_state <= S_SCALE;
                    end
                end

                S_SCALE: begin
                    r_x   <= r_x + {r_x[32:0], 2'b00};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_DINIT;
                end

                S_DINIT: begin
                    // num * 10000 + den / 2; top part stays below den
                    r_rem   <= {1'b0, dividend[38:14]};
                    r_qsh   <= dividend[13:0];
                    r_cnt   <= DIV_STEPS - 1'b1;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_rem <= rem_ge ? rem_shift - {1'b0, r_acc_den} : rem_shift;
                    r_qsh <= {r_qsh[12:0], rem_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_MIR;
                end

                S_MIR: begin
                    r_p     <= r_mirror ? FULL_SCALE - r_qsh : r_qsh;
                    r_state <= S_UPD;
                end

                S_UPD: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out.pot_number <= r_in.pot_index;
                        r_state          <= S_IDLE;
                        if (!r_in_range) begin
                            r_out.position <= '0;
                            r_out.pulled   <= 1'b0;
                            r_out.outcome  <= OUT_DISCARD;
                        end else if (r_hold) begin
                            r_out.position <= cur_c;
                            r_out.pulled   <= r_pull[r_idx];
                            r_out.outcome  <= r_outcome;
                        end else begin
                            // debounce the pull state
                            if (r_pulled_now != r_pull[r_idx]) begin
                                if (cnt_inc >= CNT_W'(PULL_CONFIRM_COUNT)) begin
                                    r_pull[r_idx]      <= r_pulled_now;
                                    r_agree_cnt[r_idx] <= '0;
                                    r_out.pulled       <= r_pulled_now;
                                end else begin
                                    r_agree_cnt[r_idx] <= cnt_inc;
                                    r_out.pulled       <= r_pull[r_idx];
                                end
                            end else begin
                                r_agree_cnt[r_idx] <= '0;
                                r_out.pulled       <= r_pull[r_idx];
                            end
                            // jump filter
                            if (diff_c > r_jump_thr && !(r_pend_vld[r_idx] &&
                                                         diff_p < r_conf_tol)) begin
                                r_pending[r_idx]  <= r_p;
                                r_pend_vld[r_idx] <= 1'b1;
                                r_out.position    <= cur_c;
                                r_out.outcome     <= OUT_PENDING;
                            end else begin
                                r_committed[r_idx] <= r_p;
                                r_pend_vld[r_idx]  <= 1'b0;
                                r_out.position     <= r_p;
                                r_out.outcome      <= OUT_COMMIT;
                            end
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PPSQ_ASSERT_IMPL(a_div_rem_below_den, i_clk, i_rst_n, r_state == S_DIV, r_rem < 26'(r_acc_den))
    `PPSQ_ASSERT_IMPL(a_out_pos_in_range, i_clk, i_rst_n, o_out_valid, o_out_data.position <= FULL_SCALE)
    `PPSQ_ASSERT_NEXT(a_upd_gives_result, i_clk, i_rst_n, r_state == S_UPD && out_free, o_out_valid && !o_in_stall)

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Push-pull pot sample qualifier testbench
// Drives pot scans through the valid/stall input channel and checks every
// result against typed values or a local model of sense classification, pull
// debounce, calibrated position and jump confirmation. A short table of
// directed scans comes first, then random scans under several calibration
// and threshold settings, most with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import ppsq_pkg::*;

    localparam int SCAN_POTS     = 6;
    localparam int PULL_CONFIRM  = 8;
    localparam int QUIET_LIMIT   = 3000;
    localparam int BLOCK_SCANS   = 305;
    localparam int REPORT_CAP    = 40;

    // sense bands as s * 330 against 100 * 4095 * volts
    localparam int unsigned NRM_PULL_LVL  = 61425;    // 0.15 V
    localparam int unsigned NRM_PRESS_LVL = 491400;   // 1.2 V
    localparam int unsigned MIR_PULL_LVL  = 1023750;  // 2.5 V
    localparam int unsigned MIR_PRESS_LVL = 1269450;  // 3.1 V

    typedef enum logic [1:0] {SNS_PRESSED, SNS_PULLED, SNS_FLIGHT} t_sense_cls;

    typedef struct packed {
        t_in_item  scan;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    // want is typed in only where it is obvious; other rows use the model
    localparam t_stim_row DIRECTED_ROWS [25] = '{
        '{'{3'd0, 12'd1000, 12'd0,    16'sd0},     1'b1, '{3'd0, 14'd0, 1'b0, OUT_DISCARD}},
        '{'{3'd1, 12'd0,    12'd4095, 16'sd100},   1'b1, '{3'd1, 14'd0, 1'b0, OUT_MISMATCH}},
        '{'{3'd6, 12'd0,    12'd0,    16'sd0},     1'b1, '{3'd6, 14'd0, 1'b0, OUT_DISCARD}},
        '{'{3'd7, 12'd4095, 12'd4095, 16'shffff},  1'b1, '{3'd7, 14'd0, 1'b0, OUT_DISCARD}},
        '{'{3'd0, 12'd4095, 12'd4095, 16'sh8000},  1'b1, '{3'd0, 14'd0, 1'b0, OUT_COMMIT}},
        '{'{3'd0, 12'd4095, 12'd4095, 16'sh7fff},  1'b1, '{3'd0, 14'd0, 1'b0, OUT_PENDING}},
        '{'{3'd0, 12'd4095, 12'd4095, 16'sh7fff},  1'b1,
          '{3'd0, 14'd10000, 1'b0, OUT_COMMIT}},
        '{'{3'd3, 12'd4095, 12'd4095, 16'sh7fff},  1'b1, '{3'd3, 14'd0, 1'b0, OUT_COMMIT}},
        '{'{3'd3, 12'd3500, 12'd3500, 16'sd100},   1'b1, '{3'd3, 14'd0, 1'b0, OUT_DISCARD}},
        '{'{3'd4, 12'd186,  12'd187,  16'sd1000},  1'b0, '0},
        '{'{3'd4, 12'd1490, 12'd1489, 16'sd1000},  1'b0, '0},
        '{'{3'd2, 12'd0,    12'd100,  16'sd13000}, 1'b0, '0},
        '{'{3'd2, 12'd0,    12'd100,  16'sd13000}, 1'b0, '0},
        '{'{3'd2, 12'd0,    12'd100,  16'sd13000}, 1'b0, '0},
        '{'{3'd2, 12'd0,    12'd100,  16'sd13000}, 1'b0, '0},
        '{'{3'd2, 12'd0,    12'd100,  16'sd13000}, 1'b0, '0},
        '{'{3'd2, 12'd0,    12'd100,  16'sd13000}, 1'b0, '0},
        '{'{3'd2, 12'd0,    12'd100,  16'sd13000}, 1'b0, '0},
        '{'{3'd2, 12'd0,    12'd100,  16'sd13000}, 1'b0, '0},
        '{'{3'd2, 12'd4095, 12'd1490, 16'sd5000},  1'b0, '0},
        '{'{3'd3, 12'd3102, 12'd3847, 16'sd2000},  1'b0, '0},
        '{'{3'd5, 12'd4095, 12'd4095, 16'sd26000}, 1'b0, '0},
        '{'{3'd5, 12'd2000, 12'd3000, 16'sd25999}, 1'b0, '0},
        '{'{3'd1, 12'd4095, 12'd4095, 16'sd9},     1'b0, '0},
        '{'{3'd3, 12'd0,    12'd0,    16'sd8},     1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [39:0] i_cfg_data;

    // local copy of the block's registers and per-pot state
    logic [39:0] cal_copy [SCAN_POTS];
    int          jump_thr;
    int          conf_tol;
    int          held_pos   [SCAN_POTS];
    int          cand_pos   [SCAN_POTS];
    bit          cand_valid [SCAN_POTS];
    bit          pull_dbn   [SCAN_POTS];
    int          pull_run   [SCAN_POTS];

    // stimulus shaping per pot
    bit          want_pulled [8];
    int          last_raw    [8];

    t_out_item   due_reports [$];
    int          err_cnt = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles = 0;

    pushpull_pot_sample_qualifier_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_sense_cls sense_class(logic [11:0] s, bit mirror);
        int unsigned m;
        m = s * 330;
        if (mirror) begin
            if (m > MIR_PRESS_LVL) return SNS_PRESSED;
            if (m < MIR_PULL_LVL) return SNS_PULLED;
            return SNS_FLIGHT;
        end
        if (m < NRM_PULL_LVL) return SNS_PULLED;
        if (m > NRM_PRESS_LVL) return SNS_PRESSED;
        return SNS_FLIGHT;
    endfunction

    function automatic int wiper_position(int pot, logic signed [15:0] raw, bit now_pulled);
        longint lo, hi, rn, rd, num, den;
        int     p;
        lo = now_pulled ? cal_copy[pot][29:20] : cal_copy[pot][9:0];
        hi = now_pulled ? cal_copy[pot][39:30] : cal_copy[pot][19:10];
        // zero span is final, no mirroring
        if (hi == lo) return 0;
        if (raw >= 26000) begin
            rn = 1000000;
            rd = 1;
        end else if (raw <= 8) begin
            rn = 0;
            rd = 1;
        end else begin
            rn = 330 * longint'(raw);
            rd = 26400 - longint'(raw);
        end
        num = rn - lo * rd;
        den = rd * (hi - lo);
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0) p = 0;
        else if (num >= den) p = 10000;
        else p = int'((num * 10000 + den / 2) / den);
        if (pot == REVERSED_POT) p = 10000 - p;
        return p;
    endfunction

    function automatic int pos_gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // advance the local state by one accepted scan and return its result
    function automatic t_out_item qualify_scan(t_in_item s);
        t_out_item  r;
        t_sense_cls c1, c2;
        int         pot;
        int         p;
        bit         now_pulled;
        pot = s.pot_index;
        r.pot_number = s.pot_index;
        if (pot >= SCAN_POTS) begin
            r.position = '0;
            r.pulled   = 1'b0;
            r.outcome  = OUT_DISCARD;
            return r;
        end
        c1 = sense_class(s.sense_before, s.pot_index == REVERSED_POT);
        c2 = sense_class(s.sense_after, s.pot_index == REVERSED_POT);
        if (c1 == SNS_FLIGHT) begin
            r.outcome = OUT_DISCARD;
        end else if (c1 != c2) begin
            r.outcome = OUT_MISMATCH;
        end else begin
            now_pulled = (c1 == SNS_PULLED);
            if (now_pulled != pull_dbn[pot]) begin
                pull_run[pot] = (pull_run[pot] + 1) & 15;
                if (pull_run[pot] >= PULL_CONFIRM) begin
                    pull_dbn[pot] = now_pulled;
                    pull_run[pot] = 0;
                end
            end else begin
                pull_run[pot] = 0;
            end
            p = wiper_position(pot, s.wiper_sample, now_pulled);
            if (pos_gap(p, held_pos[pot]) > jump_thr) begin
                if (cand_valid[pot] && pos_gap(p, cand_pos[pot]) < conf_tol) begin
                    held_pos[pot]   = p;
                    cand_valid[pot] = 1'b0;
                    r.outcome       = OUT_COMMIT;
                end else begin
                    cand_pos[pot]   = p;
                    cand_valid[pot] = 1'b1;
                    r.outcome       = OUT_PENDING;
                end
            end else begin
                held_pos[pot]   = p;
                cand_valid[pot] = 1'b0;
                r.outcome       = OUT_COMMIT;
            end
        end
        r.position = held_pos[pot][13:0];
        r.pulled   = pull_dbn[pot];
        return r;
    endfunction

    function automatic logic [11:0] sense_in_band(t_sense_cls c, bit mirror);
        case (c)
            SNS_PULLED: begin
                return mirror ? $urandom_range(MIR_PULL_MAX) : $urandom_range(NRM_PULL_MAX);
            end
            SNS_PRESSED: begin
                return mirror ? $urandom_range(4095, MIR_PRESS_MIN)
                              : $urandom_range(4095, NRM_PRESS_MIN);
            end
            default: begin
                return mirror ? $urandom_range(MIR_PRESS_MIN - 1, MIR_PULL_MAX + 1)
                              : $urandom_range(NRM_PRESS_MIN - 1, NRM_PULL_MAX + 1);
            end
        endcase
    endfunction

    // mostly well-formed scans that hold a pull class per pot long enough
    // to debounce, and wiper values that wander or jump
    function automatic t_in_item random_scan();
        t_in_item    s;
        t_sense_cls  c;
        bit          mirror;
        int          pick;
        int          pot;
        int          raw;
        logic [15:0] bits16;
        if ($urandom_range(49) == 0) s.pot_index = $urandom_range(7, 6);
        else s.pot_index = $urandom_range(SCAN_POTS - 1);
        pot = s.pot_index;
        mirror = (s.pot_index == REVERSED_POT);
        if ($urandom_range(9) == 0) want_pulled[pot] = !want_pulled[pot];
        c = want_pulled[pot] ? SNS_PULLED : SNS_PRESSED;
        pick = $urandom_range(99);
        s.sense_before = sense_in_band((pick < 8) ? SNS_FLIGHT : c, mirror);
        s.sense_after  = sense_in_band((pick >= 90) ? t_sense_cls'($urandom_range(2)) : c,
                                       mirror);
        pick = $urandom_range(99);
        if (pick < 60) begin
            raw = last_raw[pot] + int'($urandom_range(80)) - 40;
        end else if (pick < 85) begin
            raw = $urandom_range(20000);
        end else begin
            bits16 = $urandom();
            raw = $signed(bits16);
        end
        if (raw > 32767) raw = 32767;
        if (raw < -32768) raw = -32768;
        last_raw[pot] = raw;
        s.wiper_sample = raw[15:0];
        return s;
    endfunction

    // four 10-bit fields; now and then zero or negative span
    function automatic logic [39:0] random_cal();
        logic [39:0] v;
        int          lo, hi;
        for (int k = 0; k < 2; k++) begin
            case ($urandom_range(9))
                0: begin
                    lo = $urandom_range(1023);
                    hi = lo;
                end
                1, 2: begin
                    lo = $urandom_range(1023);
                    hi = $urandom_range(1023);
                end
                default: begin
                    lo = $urandom_range(300);
                    hi = $urandom_range(1023, lo + 1);
                end
            endcase
            v[k*20 +: 10]      = lo[9:0];
            v[k*20 + 10 +: 10] = hi[9:0];
        end
        return v;
    endfunction

    task automatic offer_scan(input t_in_item s, input logic typed, input t_out_item want);
        t_out_item r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        r = qualify_scan(s);
        due_reports.push_back(typed ? want : r);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        // let the last state update land
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [39:0] image [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(i);
            i_cfg_data <= image[i];
            @(posedge i_clk);
            if (i < CAL_COUNT) cal_copy[i] = image[i];
            else if (3'(i) == REG_JUMP_THR) jump_thr = image[i][13:0];
            else conf_tol = image[i][13:0];
        end
        i_cfg_we <= 1'b0;
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result check
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_reports.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none, got pot %0d pos %0d",
                             $time, o_out_data.pot_number, o_out_data.position);
            end else begin
                want = due_reports.pop_front();
                if (o_out_data.pot_number != want.pot_number ||
                    o_out_data.position != want.position ||
                    o_out_data.pulled != want.pulled ||
                    o_out_data.outcome != want.outcome) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_CAP)
                        $display({"%0t: result mismatch, expected pot %0d pos %0d pulled %0d",
                                  " outcome %0d, got pot %0d pos %0d pulled %0d outcome %0d"},
                                 $time, want.pot_number, want.position, want.pulled,
                                 want.outcome, o_out_data.pot_number, o_out_data.position,
                                 o_out_data.pulled, o_out_data.outcome);
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [39:0] image [8];
        send_idle_pct  = 18;
        recv_stall_pct = 51;
        for (int i = 0; i < CAL_COUNT; i++) cal_copy[i] = CAL_RESET[i];
        jump_thr   = JUMP_THR_RESET;
        conf_tol   = CONF_TOL_RESET;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            offer_scan(DIRECTED_ROWS[i].scan, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int blk = 0; blk < 6; blk++) begin
            if (blk > 0) begin
                drain_results();
                for (int i = 0; i < CAL_COUNT; i++) image[i] = random_cal();
                case (blk)
                    1: begin
                        image[REG_JUMP_THR] = 0;
                        image[REG_CONF_TOL] = 10000;
                    end
                    2: begin
                        // zero span on both classes, the mirror pot among them
                        image[0] = '0;
                        image[REVERSED_POT] = '1;
                        image[REG_JUMP_THR] = 10000;
                        image[REG_CONF_TOL] = 0;
                    end
                    default: begin
                        image[REG_JUMP_THR] = $urandom_range(3000);
                        image[REG_CONF_TOL] = $urandom_range(1500);
                    end
                endcase
                program_regs(image);
            end
            case (blk)
                0, 1: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 51;
                end
                2, 3: begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 18;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (BLOCK_SCANS) offer_scan(random_scan(), 1'b0, '0);
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && due_reports.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[pushpull_pot_sample_qualifier_top.f]
+incdir+rtl
rtl/ppsq_pkg.sv
rtl/pushpull_pot_sample_qualifier_top.sv
sim/tb_top.sv
